FILE: rtl/core/u8dr_pkg.sv
// ----------------------------------------------------------------------------
// u8dr_pkg
// shared types and constants of the utf-8 decoder with replacement
// ----------------------------------------------------------------------------
package u8dr_pkg;

  localparam logic [20:0] REPL_CP   = 21'h00FFFD;
  localparam logic [20:0] MAX_CP    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2   = 21'h000080;
  localparam logic [20:0] MIN_CP3   = 21'h000800;
  localparam logic [20:0] MIN_CP4   = 21'h010000;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  localparam logic [2:0]  LEN2 = 3'd2;
  localparam logic [2:0]  LEN3 = 3'd3;
  localparam logic [2:0]  LEN4 = 3'd4;

  typedef struct packed {
    logic [20:0] code_point;
    logic [7:0]  byte_count;
    logic        replaced;
    logic        last_of_run;
    logic        text_done;
  } u8dr_result_t;

  function automatic u8dr_result_t make_result(input logic [20:0] cp,
                                               input logic [7:0]  cnt,
                                               input logic        rep);
    u8dr_result_t r;
    r.code_point  = cp;
    r.byte_count  = cnt;
    r.replaced    = rep;
    r.last_of_run = 1'b0;
    r.text_done   = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/core/utf8_decoder_replacement.sv
// ----------------------------------------------------------------------------
// utf8_decoder_replacement
// byte-wide utf-8 decoder giving code points, with u+fffd for bad input
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one text byte per request (tdata = byte, tlast = end of text).
//   m_* carries decoded results: tdata = code point and byte count, tuser =
//   replaced flag and last-of-run flag, tlast = last result of the text.
//   A byte causes zero, one or two results. A byte is decoded in the cycle it
//   is accepted and its results are registered into a four-entry result
//   queue, whose head drives m_tvalid and the other m_* outputs.
//   Throughput is one byte per cycle while the receiver takes one result per
//   cycle and the queue has room; a byte that flushes a cut-short sequence or
//   a stray run and then also gives its own result pushes two results.
//   s_tready is high while the result queue holds two entries or fewer, so
//   the four-entry queue never overflows; nothing is lost or repeated under
//   stalls on either side.
//   Reset empties the result queue and returns the decoder to idle.
// ----------------------------------------------------------------------------
module utf8_decoder_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // code_point[20:0], byte_count[28:21], zero pad
  output logic [1:0]  m_tuser,   // replaced[0], last_of_run[1]
  output logic        m_tlast    // text_done
);
  import u8dr_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SEQ,
    MODE_STRAY
  } mode_t;

  mode_t        mode, mode_next;
  logic [2:0]   exp_len, exp_len_next;
  logic [2:0]   taken_len, taken_len_next;
  logic [20:0]  partial, partial_next;
  logic [7:0]   stray_count, stray_count_next;

  u8dr_result_t queue [4];
  logic [1:0]   head, tail;
  logic [2:0]   count;

  logic         s_acc, m_acc;
  logic         cont, eot;
  logic         pre_v, idl_v, use_idle;
  u8dr_result_t pre, idl, r0, r1;
  logic [1:0]   n_push;
  logic [20:0]  pv_new;
  logic [2:0]   tk;
  logic [20:0]  min_cp;
  logic         bad;
  logic [7:0]   stray_sat;
  u8dr_result_t head_res;

  assign s_tready = (count <= 3'd2);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign m_acc    = m_tvalid && m_tready;

  assign cont      = (s_tdata[7:6] == 2'b10);
  assign eot       = s_tlast;
  assign pv_new    = {partial[14:0], s_tdata[5:0]};
  assign tk        = taken_len + 3'd1;
  assign stray_sat = (stray_count == COUNT_MAX) ? stray_count : stray_count + 8'd1;

  always_comb begin
    case (exp_len)
      LEN2:    min_cp = MIN_CP2;
      LEN3:    min_cp = MIN_CP3;
      default: min_cp = MIN_CP4;
    endcase
  end

  assign bad = (pv_new < min_cp) || (pv_new > MAX_CP) ||
               ((pv_new >= SURR_LO) && (pv_new <= SURR_HI));

  // per-byte decode
  always_comb begin
    mode_next        = mode;
    exp_len_next     = exp_len;
    taken_len_next   = taken_len;
    partial_next     = partial;
    stray_count_next = stray_count;
    pre_v            = 1'b0;
    pre              = make_result(REPL_CP, 8'd1, 1'b1);
    idl_v            = 1'b0;
    idl              = make_result(REPL_CP, 8'd1, 1'b1);
    use_idle         = 1'b0;

    unique case (mode)
      MODE_STRAY: begin
        if (cont) begin
          stray_count_next = stray_sat;
          if (eot) begin
            pre_v            = 1'b1;
            pre              = make_result(REPL_CP, stray_sat, 1'b1);
            mode_next        = MODE_IDLE;
            stray_count_next = 8'd0;
          end
        end else begin
          pre_v    = 1'b1;
          pre      = make_result(REPL_CP, stray_count, 1'b1);
          use_idle = 1'b1;
        end
      end
      MODE_SEQ: begin
        if (cont) begin
          partial_next   = pv_new;
          taken_len_next = tk;
          if (tk >= exp_len) begin
            pre_v = 1'b1;
            pre   = bad ? make_result(REPL_CP, {5'd0, exp_len}, 1'b1)
                        : make_result(pv_new, {5'd0, exp_len}, 1'b0);
            use_idle = 1'b0;
          end else if (eot) begin
            pre_v = 1'b1;
            pre   = make_result(REPL_CP, {5'd0, tk}, 1'b1);
          end
          if ((tk >= exp_len) || eot) begin
            mode_next      = MODE_IDLE;
            exp_len_next   = 3'd0;
            taken_len_next = 3'd0;
            partial_next   = 21'd0;
          end
        end else begin
          pre_v    = 1'b1;
          pre      = make_result(REPL_CP, {5'd0, taken_len}, 1'b1);
          use_idle = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    if (use_idle) begin
      mode_next        = MODE_IDLE;
      exp_len_next     = 3'd0;
      taken_len_next   = 3'd0;
      partial_next     = 21'd0;
      stray_count_next = 8'd0;
      if (!s_tdata[7]) begin
        idl_v = 1'b1;
        idl   = make_result({13'd0, s_tdata}, 8'd1, 1'b0);
      end else if (cont) begin
        if (eot) begin
          idl_v = 1'b1;
        end else begin
          mode_next        = MODE_STRAY;
          stray_count_next = 8'd1;
        end
      end else if (s_tdata[7:3] == 5'b11111 || eot) begin
        idl_v = 1'b1;
      end else begin
        mode_next      = MODE_SEQ;
        taken_len_next = 3'd1;
        if (s_tdata[7:5] == 3'b110) begin
          exp_len_next = LEN2;
          partial_next = {16'd0, s_tdata[4:0]};
        end else if (s_tdata[7:4] == 4'b1110) begin
          exp_len_next = LEN3;
          partial_next = {17'd0, s_tdata[3:0]};
        end else begin
          exp_len_next = LEN4;
          partial_next = {18'd0, s_tdata[2:0]};
        end
      end
    end
  end

  // order results and mark the last one of this byte
  always_comb begin
    if (pre_v) begin
      r0     = pre;
      r1     = idl;
      n_push = idl_v ? 2'd2 : 2'd1;
    end else begin
      r0     = idl;
      r1     = idl;
      n_push = idl_v ? 2'd1 : 2'd0;
    end
    if (n_push == 2'd2) begin
      r1.last_of_run = 1'b1;
      r1.text_done   = eot;
    end else begin
      r0.last_of_run = 1'b1;
      r0.text_done   = eot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      exp_len     <= 3'd0;
      taken_len   <= 3'd0;
      partial     <= 21'd0;
      stray_count <= 8'd0;
      head        <= 2'd0;
      tail        <= 2'd0;
      count       <= 3'd0;
    end else begin
      if (s_acc) begin
        mode        <= mode_next;
        exp_len     <= exp_len_next;
        taken_len   <= taken_len_next;
        partial     <= partial_next;
        stray_count <= stray_count_next;
        tail        <= tail + n_push;
      end
      if (m_acc) begin
        head <= head + 2'd1;
      end
      count <= count + (s_acc ? {1'b0, n_push} : 3'd0) - (m_acc ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && (n_push != 2'd0)) begin
      queue[tail] <= r0;
    end
    if (s_acc && (n_push == 2'd2)) begin
      queue[tail + 2'd1] <= r1;
    end
  end

  assign head_res = queue[head];
  assign m_tdata  = {3'd0, head_res.byte_count, head_res.code_point};
  assign m_tuser  = {head_res.last_of_run, head_res.replaced};
  assign m_tlast  = head_res.text_done;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_eot_idle: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tlast |=> mode == MODE_IDLE)
    else $error("decoder not idle after end of text");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("text end not on last result of its byte");

  a_repl_cp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[20:0] == REPL_CP)
    else $error("replaced result without replacement code point");

endmodule

FILE: tb/sv/utf8_result_checker.sv
// ----------------------------------------------------------------------------
// utf8_result_checker
// watches both streams of the utf-8 decoder, predicts the decoded code
// points from the accepted bytes and compares them with the results seen
// ----------------------------------------------------------------------------
module utf8_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tlast,   // end_of_text
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // code_point[20:0], byte_count[28:21], zero pad
  input  logic [1:0]  m_tuser,   // replaced[0], last_of_run[1]
  input  logic        m_tlast,   // text_done
  output int          mismatches,
  output int          outstanding
);
  import u8dr_pkg::*;

  typedef enum logic [1:0] {
    DEC_IDLE  = 2'd0,
    DEC_SEQ   = 2'd1,
    DEC_STRAY = 2'd2
  } dec_mode_e;

  dec_mode_e    mode;
  logic [2:0]   want_len;
  logic [2:0]   got_len;
  logic [20:0]  acc_value;
  logic [7:0]   stray_len;

  u8dr_result_t step_out [2];
  int           n_step;
  u8dr_result_t expected_results [$];
  int           mismatch_count = 0;

  function automatic logic is_trail(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  task automatic push_result(input logic [20:0] cp, input logic [7:0] cnt,
                             input logic rep);
    u8dr_result_t r;
    r.code_point  = cp;
    r.byte_count  = cnt;
    r.replaced    = rep;
    r.last_of_run = 1'b0;
    r.text_done   = 1'b0;
    step_out[n_step] = r;
    n_step++;
  endtask

  task automatic clear_decoder();
    mode      = DEC_IDLE;
    want_len  = 3'd0;
    got_len   = 3'd0;
    acc_value = 21'd0;
    stray_len = 8'd0;
  endtask

  task automatic decode_from_idle(input logic [7:0] b, input logic eot);
    if (!b[7]) begin
      push_result({13'd0, b}, 8'd1, 1'b0);
    end else if (is_trail(b)) begin
      if (eot) begin
        push_result(REPL_CP, 8'd1, 1'b1);
      end else begin
        mode      = DEC_STRAY;
        stray_len = 8'd1;
      end
    end else if (b[7:3] == 5'b11111 || eot) begin
      // bad lead byte, or a lead byte that ends the text
      push_result(REPL_CP, 8'd1, 1'b1);
    end else begin
      mode    = DEC_SEQ;
      got_len = 3'd1;
      if (b[7:5] == 3'b110) begin
        want_len  = LEN2;
        acc_value = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        want_len  = LEN3;
        acc_value = {17'd0, b[3:0]};
      end else begin
        want_len  = LEN4;
        acc_value = {18'd0, b[2:0]};
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [20:0] lowest;
    logic        bad;
    n_step = 0;
    case (mode)
      DEC_STRAY: begin
        if (is_trail(b)) begin
          if (stray_len != COUNT_MAX) stray_len++;
          if (eot) begin
            push_result(REPL_CP, stray_len, 1'b1);
            clear_decoder();
          end
        end else begin
          push_result(REPL_CP, stray_len, 1'b1);
          clear_decoder();
          decode_from_idle(b, eot);
        end
      end
      DEC_SEQ: begin
        if (is_trail(b)) begin
          acc_value = {acc_value[14:0], b[5:0]};
          got_len++;
          if (got_len >= want_len) begin
            lowest = (want_len == LEN2) ? MIN_CP2 :
                     (want_len == LEN3) ? MIN_CP3 : MIN_CP4;
            bad = acc_value < lowest || acc_value > MAX_CP ||
                  (acc_value >= SURR_LO && acc_value <= SURR_HI);
            push_result(bad ? REPL_CP : acc_value, {5'd0, want_len}, bad);
            clear_decoder();
          end else if (eot) begin
            push_result(REPL_CP, {5'd0, got_len}, 1'b1);
            clear_decoder();
          end
        end else begin
          push_result(REPL_CP, {5'd0, got_len}, 1'b1);
          clear_decoder();
          decode_from_idle(b, eot);
        end
      end
      default: begin
        clear_decoder();
        decode_from_idle(b, eot);
      end
    endcase
    if (n_step > 0) begin
      step_out[n_step-1].last_of_run = 1'b1;
      step_out[n_step-1].text_done   = eot;
    end
    for (int i = 0; i < n_step; i++) expected_results.push_back(step_out[i]);
  endtask

  always @(posedge clk) begin : watch
    u8dr_result_t seen;
    u8dr_result_t want;
    if (rst) begin
      clear_decoder();
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.code_point  = m_tdata[20:0];
        seen.byte_count  = m_tdata[28:21];
        seen.replaced    = m_tuser[0];
        seen.last_of_run = m_tuser[1];
        seen.text_done   = m_tlast;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: cp=%h cnt=%0d rep=%b last=%b done=%b",
                     seen.code_point, seen.byte_count, seen.replaced,
                     seen.last_of_run, seen.text_done);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            if (mismatch_count < 10)
              $display({"mismatch: expected cp=%h cnt=%0d rep=%b last=%b done=%b,",
                        " got cp=%h cnt=%0d rep=%b last=%b done=%b"},
                       want.code_point, want.byte_count, want.replaced,
                       want.last_of_run, want.text_done,
                       seen.code_point, seen.byte_count, seen.replaced,
                       seen.last_of_run, seen.text_done);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
    end
    outstanding <= expected_results.size();
    mismatches  <= mismatch_count;
  end

endmodule

FILE: tb/sv/tb_utf8_decoder_replacement.sv
// ----------------------------------------------------------------------------
// tb_utf8_decoder_replacement
// drives utf-8 text into the decoder, from hand-picked sequences and then
// random well-formed and broken ones, under changing stalls on both sides;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_utf8_decoder_replacement;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          mismatches;
  int          outstanding;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;
  logic        hold_taken = 1'b0;

  logic [8:0]  text_bytes [$];   // {end_of_text, byte}

  localparam logic [8:0] DIRECTED [27] = '{
    9'h000, 9'h0C2, 9'h080, 9'h0C0, 9'h0AF, 9'h0ED, 9'h0A0, 9'h080, 9'h0F4,
    9'h090, 9'h080, 9'h080, 9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0FF, 9'h080,
    9'h0BF, 9'h041, 9'h0E2, 9'h082, 9'h041, 9'h0F0, 9'h19F, 9'h180, 9'h1C3
  };

  utf8_decoder_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_left  <= 150;
      hold_taken <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic add_byte(input logic [7:0] b);
    text_bytes.push_back({1'b0, b});
  endtask

  // encode cp in len bytes whatever its size, keep only the first bytes
  task automatic add_seq(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] enc [4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) add_byte(enc[i]);
  endtask

  task automatic add_random_unit();
    int         pick;
    int         len;
    logic [8:0] tail;
    pick = $urandom_range(99);
    len  = $urandom_range(4, 2);
    if (pick < 22)
      add_seq(21'($urandom_range(127)), 1, 1);
    else if (pick < 36)
      add_seq(21'($urandom_range(21'h7FF, 21'h80)), 2, 2);
    else if (pick < 50)
      add_seq(21'($urandom_range(21'hFFFF, 21'h800)), 3, 3);
    else if (pick < 62)
      add_seq(21'($urandom_range(21'h10FFFF, 21'h10000)), 4, 4);
    else if (pick < 67)
      add_seq(21'($urandom_range((len == 2) ? 21'h7F : (len == 3) ? 21'h7FF : 21'hFFFF)),
              len, len);
    else if (pick < 71)
      add_seq(21'($urandom_range(21'hDFFF, 21'hD800)), 3, 3);
    else if (pick < 75)
      add_seq(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
    else if (pick < 84)
      add_seq(21'($urandom), len, $urandom_range(len - 1, 1));
    else if (pick < 91)
      repeat ($urandom_range(5, 1)) add_byte({2'b10, 6'($urandom)});
    else if (pick < 95)
      add_byte(8'($urandom_range(255, 248)));
    else
      add_byte(8'($urandom_range(255)));
    if ($urandom_range(14) == 0) begin
      tail = text_bytes.pop_back();
      text_bytes.push_back({1'b1, tail[7:0]});
    end
  endtask

  task automatic send_byte(input logic [8:0] item);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item[7:0];
    s_tlast  <= item[8];
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 46 : 0;
      rx_idle_pct <= (ph == 0) ? 46 : (ph == 1) ? 8 : 0;
      text_bytes.delete();
      if (ph == 0)
        foreach (DIRECTED[i]) text_bytes.push_back(DIRECTED[i]);
      if (ph == 2) begin
        hold_request <= 1'b1;
        // stray run long enough to saturate the byte count
        repeat (300) add_byte({2'b10, 6'($urandom)});
        add_byte(8'h41);
      end
      while (text_bytes.size() < 480 + ((ph == 2) ? 301 : 0)) add_random_unit();
      foreach (text_bytes[i]) send_byte(text_bytes[i]);
      wait_drained();
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/u8dr_pkg.sv
rtl/core/utf8_decoder_replacement.sv
tb/sv/utf8_result_checker.sv
tb/sv/tb_utf8_decoder_replacement.sv
